/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the line rasterizer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/blp_pkg.sv */
// ----------------------------------------------------------------------------
// blp_pkg
// shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blp_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_NEXT  = 1'b1
  } req_t;

endpackage

`default_nettype wire

/* rtl/blp_front.sv */
// ----------------------------------------------------------------------------
// blp_front
// accepts requests, works out deltas, directions and major axis of a start
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blp_front #(
  parameter int COORD_BITS = blp_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blp_pkg::COLOR_BITS_DEF,
  parameter int ENTRY_BITS = 6 * COORD_BITS + COLOR_BITS + 4
) (
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         req_type,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic        [COLOR_BITS-1:0] line_color,
  output logic                              q_push,
  input  wire logic                         q_ready,
  output logic             [ENTRY_BITS-1:0] q_data
);

  typedef struct packed {
    blp_pkg::req_t           req_type;
    logic [COORD_BITS-1:0]   start_x;
    logic [COORD_BITS-1:0]   start_y;
    logic [COORD_BITS-1:0]   end_x;
    logic [COORD_BITS-1:0]   end_y;
    logic [COORD_BITS-1:0]   abs_dx;
    logic [COORD_BITS-1:0]   abs_dy;
    logic                    x_negative;
    logic                    y_negative;
    logic                    x_major;
    logic [COLOR_BITS-1:0]   color;
  } item_t;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] mag_x;
  logic signed [COORD_BITS:0] mag_y;
  item_t                      item;

  assign dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
  assign dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
  assign mag_x = dx[COORD_BITS] ? -dx : dx;
  assign mag_y = dy[COORD_BITS] ? -dy : dy;

  always_comb begin
    item.req_type   = blp_pkg::req_t'(req_type);
    item.start_x    = start_x;
    item.start_y    = start_y;
    item.end_x      = end_x;
    item.end_y      = end_y;
    item.abs_dx     = mag_x[COORD_BITS-1:0];
    item.abs_dy     = mag_y[COORD_BITS-1:0];
    item.x_negative = dx[COORD_BITS];
    item.y_negative = dy[COORD_BITS];
    item.x_major    = mag_y[COORD_BITS-1:0] <= mag_x[COORD_BITS-1:0];
    item.color      = line_color;
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;
  assign q_data   = item;

endmodule

`default_nettype wire

/* rtl/blp_queue.sv */
// ----------------------------------------------------------------------------
// blp_queue
// small request queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = blp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/blp_back.sv */
// ----------------------------------------------------------------------------
// blp_back
// line stepper: holds the line state; a next request while idle gives no pixel, else one pixel per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blp_back #(
  parameter int COORD_BITS = blp_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blp_pkg::COLOR_BITS_DEF,
  parameter int ENTRY_BITS = 6 * COORD_BITS + COLOR_BITS + 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire logic        [ENTRY_BITS-1:0] q_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed      [COORD_BITS-1:0] pixel_x,
  output logic signed      [COORD_BITS-1:0] pixel_y,
  output logic             [COLOR_BITS-1:0] pixel_color,
  output logic                              last
);

  localparam int ERR_BITS = COORD_BITS + 3;
  localparam logic [COORD_BITS-1:0] STEP_UP   = COORD_BITS'(1);
  localparam logic [COORD_BITS-1:0] STEP_DOWN = '1;

  typedef struct packed {
    blp_pkg::req_t           req_type;
    logic [COORD_BITS-1:0]   start_x;
    logic [COORD_BITS-1:0]   start_y;
    logic [COORD_BITS-1:0]   end_x;
    logic [COORD_BITS-1:0]   end_y;
    logic [COORD_BITS-1:0]   abs_dx;
    logic [COORD_BITS-1:0]   abs_dy;
    logic                    x_negative;
    logic                    y_negative;
    logic                    x_major;
    logic [COLOR_BITS-1:0]   color;
  } item_t;

  item_t                      item;
  logic [COORD_BITS-1:0]      cur_x;
  logic [COORD_BITS-1:0]      cur_y;
  logic [COORD_BITS-1:0]      target_x;
  logic [COORD_BITS-1:0]      target_y;
  logic [COORD_BITS-1:0]      abs_dx;
  logic [COORD_BITS-1:0]      abs_dy;
  logic signed [ERR_BITS-1:0] err_acc;
  logic                       x_negative;
  logic                       y_negative;
  logic                       x_major;
  logic                       busy;
  logic [COLOR_BITS-1:0]      held_color;

  logic [COORD_BITS-1:0]      maj_d;
  logic [COORD_BITS-1:0]      min_d;
  logic signed [ERR_BITS-1:0] err_add;
  logic                       minor_step;
  logic signed [ERR_BITS-1:0] err_next;
  logic [COORD_BITS-1:0]      cur_x_next;
  logic [COORD_BITS-1:0]      cur_y_next;
  logic                       done;
  logic                       start_moves;

  assign item  = item_t'(q_data);
  assign q_pop = q_valid && (!out_valid || out_ready);

  // one bresenham step
  always_comb begin
    maj_d      = x_major ? abs_dx : abs_dy;
    min_d      = x_major ? abs_dy : abs_dx;
    err_add    = err_acc + $signed({2'b00, min_d, 1'b0});
    minor_step = err_add > $signed({3'b000, maj_d});
    err_next   = minor_step ? err_add - $signed({2'b00, maj_d, 1'b0}) : err_add;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (x_major || minor_step) begin
      cur_x_next = cur_x + (x_negative ? STEP_DOWN : STEP_UP);
    end
    if (!x_major || minor_step) begin
      cur_y_next = cur_y + (y_negative ? STEP_DOWN : STEP_UP);
    end
    done = x_major ? (cur_x_next == target_x) : (cur_y_next == target_y);
  end

  assign start_moves = (item.abs_dx != '0) || (item.abs_dy != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        case (item.req_type)
          blp_pkg::REQ_START: begin
            busy      <= start_moves;
            out_valid <= 1'b1;
          end
          blp_pkg::REQ_NEXT: begin
            if (busy) begin
              busy      <= !done;
              out_valid <= 1'b1;
            end
          end
          default: begin
            busy <= busy;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (item.req_type)
        blp_pkg::REQ_START: begin
          cur_x       <= item.start_x;
          cur_y       <= item.start_y;
          target_x    <= item.end_x;
          target_y    <= item.end_y;
          abs_dx      <= item.abs_dx;
          abs_dy      <= item.abs_dy;
          x_negative  <= item.x_negative;
          y_negative  <= item.y_negative;
          x_major     <= item.x_major;
          err_acc     <= '0;
          held_color  <= item.color;
          pixel_x     <= item.start_x;
          pixel_y     <= item.start_y;
          pixel_color <= item.color;
          last        <= !start_moves;
        end
        blp_pkg::REQ_NEXT: begin
          if (busy) begin
            cur_x       <= cur_x_next;
            cur_y       <= cur_y_next;
            err_acc     <= err_next;
            pixel_x     <= cur_x_next;
            pixel_y     <= cur_y_next;
            pixel_color <= held_color;
            last        <= done;
          end
        end
        default: begin
          cur_x <= cur_x;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/bresenham_line_pixels.sv */
// ----------------------------------------------------------------------------
// bresenham_line_pixels
// integer line rasterizer, one pixel per start request and per next-pixel request while a line is active
// a request is held in the request queue, then the stepper registers its pixel
// throughput: one request per cycle while the output is not stalled, set by the single-step error update
// a two-entry request queue separates the front from the stepper
// reset: queue emptied, output invalid, stepper idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_pixels #(
  parameter int COORD_BITS = blp_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blp_pkg::COLOR_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         req_type,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic        [COLOR_BITS-1:0] line_color,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed      [COORD_BITS-1:0] pixel_x,
  output logic signed      [COORD_BITS-1:0] pixel_y,
  output logic             [COLOR_BITS-1:0] pixel_color,
  output logic                              last
);

  localparam int ENTRY_BITS = 6 * COORD_BITS + COLOR_BITS + 4;

  logic                  q_push;
  logic                  q_ready;
  logic [ENTRY_BITS-1:0] q_wdata;
  logic                  q_valid;
  logic                  q_pop;
  logic [ENTRY_BITS-1:0] q_rdata;

  blp_front #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_color (line_color),
    .q_push     (q_push),
    .q_ready    (q_ready),
    .q_data     (q_wdata)
  );

  blp_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (blp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push),
    .push_ready (q_ready),
    .push_data  (q_wdata),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_rdata)
  );

  blp_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (last)
  );

endmodule

`default_nettype wire

/* rtl/blp_checker.sv */
// ----------------------------------------------------------------------------
// blp_checker
// port-level checks of the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module blp_checker #(
  parameter int COORD_BITS = blp_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = blp_pkg::COLOR_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COORD_BITS-1:0] pixel_x,
  input wire logic [COORD_BITS-1:0] pixel_y,
  input wire logic [COLOR_BITS-1:0] pixel_color,
  input wire logic                  last
);

  // stalled pixel holds
  `BLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) && $stable(last), "stalled pixel changed")

  // queue only fills up behind a stalled pixel
  `BLP_ASSERT(a_full_needs_stall, !in_ready |-> out_valid, "request side blocked with no pending pixel")

  // reset empties output and queue
  `BLP_ASSERT_ALWAYS(a_rst_out, rst |=> !out_valid, "pixel valid after reset")
  `BLP_ASSERT_ALWAYS(a_rst_in, rst |=> in_ready, "request side not ready after reset")

endmodule

bind bresenham_line_pixels blp_checker #(
  .COORD_BITS (COORD_BITS),
  .COLOR_BITS (COLOR_BITS)
) u_blp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color),
  .last        (last)
);

`default_nettype wire
